[rtl/dkef_pkg.sv]
// Shared types and constants for the debounced key event FIFO.
package dkef_pkg;

   // Number of keys, fixed by the widths of the request and response fields.
   localparam int NUM_KEYS = 4;
   localparam int KEY_W    = $clog2(NUM_KEYS);
   localparam int CODE_W   = $clog2(NUM_KEYS + 1);
   localparam int PFX_W    = $clog2(NUM_KEYS + 1);

   // Request kinds carried in the req_type field.
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_EDGE = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Code returned by a read of an empty FIFO.
   localparam logic [7:0] EMPTY_CODE = 8'hFF;

   // Debounce period after reset.
   localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

   // Per-key debounce state.
   typedef enum logic [1:0] {
      KEY_UP   = 2'd0,
      KEY_INT  = 2'd1,
      KEY_DOWN = 2'd2
   } key_state_type;

   // One request.
   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] key_index;
      logic [3:0] pressed_keys;
   } dkef_req_type;

   // One response.
   typedef struct packed {
      logic [7:0] read_code;
      logic       read_valid;
      logic [4:0] fifo_count;
      logic       overflow;
      logic [3:0] down_mask;
   } dkef_rsp_type;

   // FIFO outcome of one accepted request.
   typedef struct packed {
      logic       read_hit;
      logic       read_miss;
      logic [4:0] fifo_count;
      logic       overflow;
   } dkef_fifo_status_type;

endpackage

[rtl/dkef_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dkef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dkef_lane.sv]
// Debounce state and countdown for one key.
module dkef_lane (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       tick,
   input  logic       edge_hit,
   input  logic       pressed,
   input  logic [7:0] arm_value,
   output logic       push,
   output logic       down_next
);

   dkef_pkg::key_state_type state_ff, state_in;
   logic [7:0]              count_ff, count_in;

   // Next state: countdown on ticks, arming on an edge request for an up key.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      if (accept && tick && (state_ff != dkef_pkg::KEY_UP) && (count_ff != 8'd0)) begin
         if (count_ff != 8'd1) begin
            count_in = count_ff - 8'd1;
         end else if (pressed) begin
            if (state_ff == dkef_pkg::KEY_INT) begin
               state_in = dkef_pkg::KEY_DOWN;
            end
            count_in = arm_value;
         end else begin
            state_in = dkef_pkg::KEY_UP;
            count_in = 8'd0;
         end
      end else if (accept && edge_hit && (state_ff == dkef_pkg::KEY_UP)) begin
         state_in = dkef_pkg::KEY_INT;
         count_in = arm_value;
      end
   end

   // Outputs: a push when an interrupted key expires while still pressed.
   always_comb begin
      push      = accept && tick && (state_ff == dkef_pkg::KEY_INT) &&
                  (count_ff == 8'd1) && pressed;
      down_next = (state_in == dkef_pkg::KEY_DOWN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dkef_pkg::KEY_UP;
         count_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/dkef_merge.sv]
// Merges the lanes' push requests into the event FIFO and serves reads.
module dkef_merge #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              is_read,
   input  logic [dkef_pkg::NUM_KEYS-1:0]     push_mask,
   output logic                              idle,
   output dkef_pkg::dkef_fifo_status_type    status,
   output logic [dkef_pkg::CODE_W-1:0]       rd_code
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W = (CNT_W > dkef_pkg::PFX_W) ? CNT_W : dkef_pkg::PFX_W;

   logic [PTR_W-1:0]              wptr_ff, wptr_in;
   logic [PTR_W-1:0]              rptr_ff, rptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [dkef_pkg::NUM_KEYS-1:0] pending_ff, pending_in;
   logic [dkef_pkg::NUM_KEYS-1:0] kept_mask, wr_src, wr_bit;
   logic [dkef_pkg::PFX_W-1:0]    prefix, kept_cnt;
   logic [CNT_W-1:0]              free_slots;
   logic                          dropped;
   logic [dkef_pkg::KEY_W-1:0]    wr_key;
   logic                          wr_en;
   logic                          pop;
   logic [dkef_pkg::CODE_W-1:0]   wr_code;

   // Keep the pushes that fit, lowest key first; the rest are dropped.
   always_comb begin
      free_slots = CNT_W'(FIFO_DEPTH) - count_ff;
      prefix     = '0;
      kept_mask  = '0;
      dropped    = 1'b0;
      for (int i = 0; i < dkef_pkg::NUM_KEYS; i++) begin
         if (push_mask[i]) begin
            if (CMP_W'(prefix) < CMP_W'(free_slots)) begin
               kept_mask[i] = 1'b1;
               prefix       = prefix + dkef_pkg::PFX_W'(1);
            end else begin
               dropped = 1'b1;
            end
         end
      end
      kept_cnt = prefix;
   end

   // One RAM write per cycle: the lowest key still waiting to be stored.
   always_comb begin
      wr_src = accept ? kept_mask : pending_ff;
      wr_key = '0;
      for (int i = dkef_pkg::NUM_KEYS - 1; i >= 0; i--) begin
         if (wr_src[i]) begin
            wr_key = dkef_pkg::KEY_W'(i);
         end
      end
      wr_en      = (wr_src != '0);
      wr_bit     = wr_en ? (dkef_pkg::NUM_KEYS'(1) << wr_key) : '0;
      pending_in = wr_src & ~wr_bit;
      wr_code    = dkef_pkg::CODE_W'(wr_key) + dkef_pkg::CODE_W'(1);
   end

   // Pointer and count updates.
   always_comb begin
      pop      = accept && is_read && (count_ff != '0);
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rptr_in  = (rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end else if (accept) begin
         count_in = count_ff + CNT_W'(kept_cnt);
      end
   end

   // Status of the request being accepted.
   always_comb begin
      status.read_hit   = pop;
      status.read_miss  = is_read && (count_ff == '0);
      status.fifo_count = 5'(count_in);
      status.overflow   = dropped;
      idle              = (pending_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         wptr_ff    <= wptr_in;
         rptr_ff    <= rptr_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   dkef_ram #(
      .WIDTH (dkef_pkg::CODE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (wr_code),
      .rd_en   (pop),
      .rd_addr (rptr_ff),
      .rd_data (rd_code)
   );

endmodule

[rtl/debounced_key_event_fifo_top.sv]
// Pipeline: a response passes the stage register, then the output register.
// Throughput: one request per cycle while the response path does not stall; a tick
// that stores more than one key code holds the request side until all are written,
// as the event RAM takes one write per cycle. Reset is synchronous and active high:
// keys up, timers idle, FIFO empty, debounce period 20 ticks; event RAM undefined.
module debounced_key_event_fifo_top #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dkef_pkg::dkef_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dkef_pkg::dkef_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data
);

   logic [7:0]                     debounce_ff;
   logic [7:0]                     arm_value;
   logic                           accept;
   logic                           is_tick, is_edge, is_read;
   logic [dkef_pkg::NUM_KEYS-1:0]  push_mask, down_next;
   logic                           merge_idle;
   dkef_pkg::dkef_fifo_status_type status;
   logic [dkef_pkg::CODE_W-1:0]    rd_code;

   logic                           s1_valid_ff, s1_valid_in;
   dkef_pkg::dkef_fifo_status_type s1_status_ff;
   logic [3:0]                     s1_down_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   dkef_pkg::dkef_rsp_type         rsp_data_ff, rsp_data_in;
   logic                           out_free, s1_move;

   // Debounce period register; zero arms as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= dkef_pkg::DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         debounce_ff <= csr_wr_data;
      end
   end

   assign arm_value = (debounce_ff == 8'd0) ? 8'd1 : debounce_ff;

   // Handshake: the stage register and the output register move together.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = (!s1_valid_ff || s1_move) && merge_idle;
   assign accept    = req_valid && req_ready;

   assign is_tick = (req_data.req_type == dkef_pkg::REQ_TICK);
   assign is_edge = (req_data.req_type == dkef_pkg::REQ_EDGE);
   assign is_read = (req_data.req_type == dkef_pkg::REQ_READ);

   // One debounce lane per key.
   for (genvar k = 0; k < dkef_pkg::NUM_KEYS; k++) begin : g_lane
      dkef_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .tick      (is_tick),
         .edge_hit  (is_edge && (req_data.key_index == dkef_pkg::KEY_W'(k))),
         .pressed   (req_data.pressed_keys[k]),
         .arm_value (arm_value),
         .push      (push_mask[k]),
         .down_next (down_next[k])
      );
   end

   dkef_merge #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .is_read   (is_read),
      .push_mask (push_mask),
      .idle      (merge_idle),
      .status    (status),
      .rd_code   (rd_code)
   );

   // Valid flags of the stage and output registers.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   // Response assembly once the RAM read data is available.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_move) begin
         if (s1_status_ff.read_hit) begin
            rsp_data_in.read_code = 8'(rd_code);
         end else if (s1_status_ff.read_miss) begin
            rsp_data_in.read_code = dkef_pkg::EMPTY_CODE;
         end else begin
            rsp_data_in.read_code = 8'd0;
         end
         rsp_data_in.read_valid = s1_status_ff.read_hit;
         rsp_data_in.fifo_count = s1_status_ff.fifo_count;
         rsp_data_in.overflow   = s1_status_ff.overflow;
         rsp_data_in.down_mask  = s1_down_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
         s1_down_ff   <= 4'(down_next);
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
